@@ src/np_pkg.sv @@
package np_pkg;

	// Configuration port widths and register indexes.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ON_DURATION       = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_DURATION = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR       = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLOR      = 8'd3;

	localparam int TICK_W  = 16;
	localparam int COLOR_W = 3;
	localparam int KIND_W  = 2;

	localparam logic [TICK_W-1:0]  ON_DURATION_RST       = 16'd1000;
	localparam logic [TICK_W-1:0]  COOLDOWN_DURATION_RST = 16'd300;
	localparam logic [COLOR_W-1:0] FIRST_COLOR_RST       = 3'd2;
	localparam logic [COLOR_W-1:0] SECOND_COLOR_RST      = 3'd5;

	localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SECOND = 2'd2;

	typedef struct packed {
		logic [TICK_W-1:0]  on_duration;
		logic [TICK_W-1:0]  cooldown_duration;
		logic [COLOR_W-1:0] first_color;
		logic [COLOR_W-1:0] second_color;
	} cfg_t;

	// Head of the queue as the controller sees it after this tick's push.
	typedef struct packed {
		logic              avail;
		logic [KIND_W-1:0] kind;
	} fifo_stat_t;

	// Next-state view of the controller for the result register.
	typedef struct packed {
		logic               pop;
		logic               lit;
		logic [COLOR_W-1:0] color;
	} ctrl_out_t;

endpackage

@@ src/np_if.sv @@
interface np_msg_if;
	logic                     valid;
	logic                     ready;
	logic                     msg_valid;
	logic [np_pkg::KIND_W-1:0] msg_kind;

	modport source (output valid, output msg_valid, output msg_kind, input ready);
	modport sink   (input valid, input msg_valid, input msg_kind, output ready);
endinterface

interface np_res_if #(parameter int PEND_W = 5);
	logic              valid;
	logic              ready;
	logic              red_on;
	logic              green_on;
	logic              blue_on;
	logic              buzzer_on;
	logic              dropped;
	logic [PEND_W-1:0] pending;

	modport source (output valid, output red_on, output green_on, output blue_on,
		output buzzer_on, output dropped, output pending, input ready);
	modport sink   (input valid, input red_on, input green_on, input blue_on,
		input buzzer_on, input dropped, input pending, output ready);
endinterface

interface np_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [np_pkg::CFG_IDX_W-1:0]  index;
	logic [np_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/np_regs.sv @@
module np_regs (
	input  logic          clk,
	input  logic          arst_n,
	np_cfg_if.sink        cfg,
	output np_pkg::cfg_t  regs
);

	np_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.on_duration       <= np_pkg::ON_DURATION_RST;
			regs_q.cooldown_duration <= np_pkg::COOLDOWN_DURATION_RST;
			regs_q.first_color       <= np_pkg::FIRST_COLOR_RST;
			regs_q.second_color      <= np_pkg::SECOND_COLOR_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				np_pkg::REG_ON_DURATION: begin
					regs_q.on_duration <= cfg.data;
				end
				np_pkg::REG_COOLDOWN_DURATION: begin
					regs_q.cooldown_duration <= cfg.data;
				end
				np_pkg::REG_FIRST_COLOR: begin
					regs_q.first_color <= cfg.data[np_pkg::COLOR_W-1:0];
				end
				np_pkg::REG_SECOND_COLOR: begin
					regs_q.second_color <= cfg.data[np_pkg::COLOR_W-1:0];
				end
				default: begin
					// Writes outside the register list are dropped.
				end
			endcase
		end
	end

endmodule

@@ src/np_fifo.sv @@
module np_fifo #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push_req,
	input  logic [np_pkg::KIND_W-1:0]         push_kind,
	input  logic                              pop,
	output np_pkg::fifo_stat_t                stat,
	output logic [$clog2(FIFO_DEPTH+1)-1:0]   occ_next,
	output logic                              dropped
);

	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	logic [np_pkg::KIND_W-1:0] mem [FIFO_DEPTH];
	logic [np_pkg::KIND_W-1:0] head_q;
	logic [PTR_W-1:0]          rd_ptr_q;
	logic [PTR_W-1:0]          wr_ptr_q;
	logic [CNT_W-1:0]          occ_q;
	logic [PTR_W-1:0]          rd_ptr_next;
	logic                      full;
	logic                      push;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (occ_q >= CNT_W'(FIFO_DEPTH));
	assign push    = push_req && !full;
	assign dropped = push_req && full;

	// An arrival into an empty queue is the head right away.
	assign stat.avail = (occ_q != '0) || push;
	assign stat.kind  = (occ_q == '0) ? push_kind : head_q;

	assign occ_next    = occ_q + CNT_W'(push) - CNT_W'(pop);
	assign rd_ptr_next = pop ? next_ptr(rd_ptr_q) : rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			occ_q    <= occ_next;
			rd_ptr_q <= rd_ptr_next;
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
		end
	end

	// The head register always holds the entry at the next read pointer, so the
	// following tick finds it without waiting on the memory read.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_kind;
		end
		if (push && (wr_ptr_q == rd_ptr_next)) begin
			head_q <= push_kind;
		end else begin
			head_q <= mem[rd_ptr_next];
		end
	end

endmodule

@@ src/np_ctrl.sv @@
module np_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  np_pkg::cfg_t       regs,
	input  np_pkg::fifo_stat_t stat,
	output np_pkg::ctrl_out_t  ctrl
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LIT  = 2'd1;
	localparam logic [1:0] PH_COOL = 2'd2;

	logic [1:0]                  phase_q;
	logic [np_pkg::TICK_W-1:0]   elapsed_q;
	logic [np_pkg::COLOR_W-1:0]  color_q;
	logic [1:0]                  phase_d;
	logic [np_pkg::TICK_W-1:0]   elapsed_d;
	logic [np_pkg::COLOR_W-1:0]  color_d;
	logic [np_pkg::TICK_W-1:0]   elapsed_inc;
	logic                        pop;

	assign elapsed_inc = elapsed_q + 1'b1;

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		color_d   = color_q;
		pop       = 1'b0;

		case (phase_q)
			PH_LIT: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= regs.on_duration) begin
					phase_d   = PH_COOL;
					color_d   = '0;
					elapsed_d = '0;
				end
			end
			PH_COOL: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= regs.cooldown_duration) begin
					phase_d   = PH_IDLE;
					elapsed_d = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (step && (phase_d == PH_IDLE) && stat.avail) begin
			pop = 1'b1;
			if (stat.kind == np_pkg::KIND_FIRST || stat.kind == np_pkg::KIND_SECOND) begin
				color_d   = (stat.kind == np_pkg::KIND_FIRST) ? regs.first_color
					: regs.second_color;
				phase_d   = PH_LIT;
				elapsed_d = '0;
			end
		end
	end

	assign ctrl.pop   = pop;
	assign ctrl.lit   = (phase_d == PH_LIT);
	assign ctrl.color = color_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			color_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			color_q   <= color_d;
		end
	end

endmodule

@@ src/notification_pacer.sv @@
// Channel   Modport  Transaction carries
// msg       sink     msg_valid, msg_kind: one millisecond tick, maybe with a notification
// res       source   red_on, green_on, blue_on, buzzer_on, dropped, pending
// cfg       sink     index, data: one register write, always ready
//
// One tick transaction is taken every cycle while res is not stalled; each produces
// exactly one result transaction, held first in the input register and then in the
// result register. The rate is set by the phase timer and the queue pointers updating
// once per tick; they sit between those two registers.
// Reset is asynchronous and clears the pointers, occupancy, phase, timer, color
// and the valid bits of both stages; the queue storage is not cleared and needs no sweep.
// While res is stalled the result holds and one more tick waits in the input register.
module notification_pacer #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	np_msg_if.sink    msg,
	np_res_if.source  res,
	np_cfg_if.sink    cfg
);

	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// Input stage.
	logic                      valid_s1;
	logic                      msg_valid_s1;
	logic [np_pkg::KIND_W-1:0] msg_kind_s1;

	// Result stage.
	logic                       res_valid_s2;
	logic [np_pkg::COLOR_W-1:0] color_s2;
	logic                       buzzer_s2;
	logic                       dropped_s2;
	logic [CNT_W-1:0]           pending_s2;

	logic                step;
	logic                msg_accept;
	np_pkg::cfg_t        regs;
	np_pkg::fifo_stat_t  stat;
	np_pkg::ctrl_out_t   ctrl;
	logic [CNT_W-1:0]    occ_next;
	logic                dropped;

	// A tick is processed when the result register is free or being emptied.
	assign step       = valid_s1 && (!res_valid_s2 || res.ready);
	assign msg.ready  = !valid_s1 || step;
	assign msg_accept = msg.valid && msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_accept) begin
			msg_valid_s1 <= msg.msg_valid;
			msg_kind_s1  <= msg.msg_kind;
		end
	end

	np_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	np_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_req  (step && msg_valid_s1),
		.push_kind (msg_kind_s1),
		.pop       (ctrl.pop),
		.stat      (stat),
		.occ_next  (occ_next),
		.dropped   (dropped)
	);

	np_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.regs   (regs),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (step) begin
			res_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			color_s2   <= ctrl.color;
			buzzer_s2  <= ctrl.lit;
			dropped_s2 <= dropped;
			pending_s2 <= occ_next;
		end
	end

	// Color bits: bit 2 red, bit 1 green, bit 0 blue.
	assign res.valid     = res_valid_s2;
	assign res.red_on    = color_s2[2];
	assign res.green_on  = color_s2[1];
	assign res.blue_on   = color_s2[0];
	assign res.buzzer_on = buzzer_s2;
	assign res.dropped   = dropped_s2;
	assign res.pending   = pending_s2;

endmodule
